// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lphl_pkg.sv =====
// ----------------------------------------------------------------------------
// lphl_pkg
// Types and constants for the linear probing hash lookup.
// ----------------------------------------------------------------------------
package lphl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int KEY_W       = 32;
    localparam int ITEM_W      = 16;
    localparam int SLOT_W      = 10;
    localparam int LOG2_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT      = 2'd2;

    localparam logic [LOG2_W-1:0] RESET_TABLE_SIZE_LOG2 = 4'd10;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot_index;
        logic [KEY_W-1:0]  key_hash;
        logic [ITEM_W-1:0] entry_item;
    } t_in_beat;

    typedef struct packed {
        logic              found;
        logic [ITEM_W-1:0] item_index;
    } t_out_beat;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] item;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

endpackage

// ===== hw/rtl/linear_probe_hash_lookup.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_lookup
// Open-addressing hash table with linear probing, one probe per cycle.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): a write beat stores a
// key and item index in one slot and returns nothing; a lookup beat returns
// one beat on the output channel (o_out_valid / i_out_stall / o_out_data).
// Config channel (i_cfg_valid / o_cfg_ready): register index and data; it is
// always ready, also during the clearing pass.
// Throughput: a write leaves the block idle for the next beat; a lookup
// stalls the input through its P probes (1 to active size): the slot memory
// is read once per cycle and each read data word is checked the cycle after
// its address. A disabled table answers after its first probe.
// Result: the beat is registered once the final probe is checked.
// Reset: the slot memory is cleared one entry per cycle, all TABLE_DEPTH
// entries, with the input stalled; configuration returns to its reset values.
// Output stall: the result stays in the output register; the next write can
// still be taken, a following lookup holds its final probe until the output
// register drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_lookup #(
    parameter int TABLE_DEPTH = lphl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lphl_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lphl_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lphl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lphl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lphl_pkg::*;

    localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;

    // configuration
    logic [LOG2_W-1:0] r_log2;
    logic              r_enabled;
    logic [ITEM_W-1:0] r_item_count;

    // control
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_slot;
    logic [AW-1:0]     r_cnt;
    logic [KEY_W-1:0]  r_key;
    logic              r_dis;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              in_acc;
    logic              out_free;
    logic              lookup_acc;
    logic [4:0]        eff_log2;
    logic [AW:0]       size_pow;
    logic [AW:0]       size_m1;
    logic [AW-1:0]     mask;
    logic [AW-1:0]     start_slot;
    logic [AW-1:0]     next_slot;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic              wr_in_range;
    logic              hit;
    logic              empty;
    logic              done;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_entry            wr_entry;
    logic [AW-1:0]     rd_addr;
    t_entry            rd_entry;

    lphl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2       <= RESET_TABLE_SIZE_LOG2;
            r_enabled    <= 1'b0;
            r_item_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TABLE_SIZE_LOG2: r_log2       <= i_cfg_data[LOG2_W-1:0];
                CFG_TABLE_ENABLED:   r_enabled    <= i_cfg_data[0];
                CFG_ITEM_COUNT:      r_item_count <= i_cfg_data[ITEM_W-1:0];
                default: ;
            endcase
        end
    end

    // active size clamps to the largest power of two within the memory
    assign eff_log2   = (int'(r_log2) > MAX_LOG2) ? 5'(MAX_LOG2) : {1'b0, r_log2};
    assign size_pow   = (AW+1)'(1) << eff_log2;
    assign size_m1    = size_pow - (AW+1)'(1);
    assign mask       = size_m1[AW-1:0];
    assign start_slot = i_in_data.key_hash[AW-1:0] & mask;
    assign next_slot  = (r_slot + AW'(1)) & mask;

    assign slot_ext    = {{AW{1'b0}}, i_in_data.slot_index};
    assign wr_in_range = int'(i_in_data.slot_index) < TABLE_DEPTH;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign lookup_acc = in_acc && (i_in_data.mode == MODE_LOOKUP);
    assign out_free   = !r_out_valid || !i_out_stall;

    // an empty slot ends the walk before any key compare
    assign empty = (rd_entry.key == '0);
    assign hit   = !empty && (rd_entry.key == r_key) && (rd_entry.item < r_item_count);
    assign done  = r_dis || empty || hit || (r_cnt == mask);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (lookup_acc) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (done && out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = r_clr_addr;
        wr_entry   = '0;
        rd_addr    = r_slot;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                rd_addr    = start_slot;
                if (in_acc && (i_in_data.mode == MODE_WRITE) && wr_in_range) begin
                    wr_en    = 1'b1;
                    wr_addr  = slot_ext[AW-1:0];
                    wr_entry = '{key: i_in_data.key_hash, item: i_in_data.entry_item};
                end
            end
            S_PROBE: begin
                rd_addr = done ? r_slot : next_slot;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == S_PROBE && done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lookup_acc) begin
            r_slot <= start_slot;
            r_cnt  <= '0;
            r_key  <= i_in_data.key_hash;
            r_dis  <= !r_enabled;
        end else if (r_state == S_PROBE && !done) begin
            r_slot <= next_slot;
            r_cnt  <= r_cnt + AW'(1);
        end
        if (r_state == S_PROBE && done && out_free) begin
            r_out.found      <= !r_dis && hit;
            r_out.item_index <= (!r_dis && hit) ? rd_entry.item : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_CLK(a_found_in_range, i_clk, i_rst_n, (o_out_valid && o_out_data.found) |-> (o_out_data.item_index < r_item_count), "found item index not below item count")
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (o_out_valid && !o_out_data.found) |-> (o_out_data.item_index == '0), "miss carries nonzero item index")
    `ASSERT_CLK(a_probe_bound, i_clk, i_rst_n, (r_state == S_PROBE) |-> (r_cnt <= mask), "probe count beyond active size")
    `ASSERT_CLK(a_lookup_probes, i_clk, i_rst_n, lookup_acc |=> (r_state == S_PROBE), "accepted lookup did not start probing")
    `ASSERT_CLK(a_clear_no_result, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !o_out_valid, "result during clearing pass")

endmodule

// ===== hw/rtl/lphl_table.sv =====
// ----------------------------------------------------------------------------
// lphl_table
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lphl_table #(
    parameter int DEPTH = lphl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  lphl_pkg::t_entry i_wr_entry,
    input  logic [AW-1:0]   i_rd_addr,
    output lphl_pkg::t_entry o_rd_entry
);
    import lphl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probing hash lookup.
// A directed table covers the reset state, the field extremes and the corner
// cases of the probe walk. Randomized phases follow: each phase programs the
// registers while the block is idle, then streams slot writes and lookups.
// Lookups are checked against a local slot table model or a row's given answer.
// ----------------------------------------------------------------------------
module tb;
    import lphl_pkg::*;

    localparam int DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int N_RANDOM = 420;
    localparam int SETTLE   = 8;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in_beat              beat;
        logic                  typed;
        t_out_beat             answer;
    } t_row;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_beat              in_beat   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out_beat             o_out_data;

    logic [KEY_W-1:0]  tbl_key  [DEPTH];
    logic [ITEM_W-1:0] tbl_item [DEPTH];
    logic [LOG2_W-1:0] cur_log2    = RESET_TABLE_SIZE_LOG2;
    logic              cur_enabled = 1'b0;
    logic [ITEM_W-1:0] cur_count   = '0;
    t_out_beat         answer_q [$];
    bit                steady = 1'b0;
    int err_count = 0;
    int n_writes  = 0;
    int n_lookups = 0;
    int n_hits    = 0;
    int n_regs    = 0;

    t_row dir_rows [27] = '{
        // disabled after reset: every lookup misses
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{1'b0, 16'h0}},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'hFFFF_FFFF, 16'h0000}, 1'b1, '{1'b0, 16'h0}},
        '{1'b1, CFG_TABLE_ENABLED, 16'd1, '0, 1'b0, '0},
        '{1'b1, CFG_ITEM_COUNT, 16'hFFFF, '0, 1'b0, '0},
        // key matches but index FFFF is not below the count
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h155, 32'hFFFF_FFFF, 16'h0000}, 1'b1, '{1'b0, 16'h0}},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h000, 32'hFFFF_FFFF, 16'h1234}, 1'b0, '0},
        // wraps from the last slot to slot 0
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h2AA, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0000, 16'h0000}, 1'b1, '{1'b0, 16'h0}},
        // key zero written: slot becomes empty
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h000, 32'h0000_0000, 16'hABCD}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
        '{1'b1, CFG_TABLE_SIZE_LOG2, 16'd2, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h000, 32'h0000_0010, 16'h0001}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h001, 32'h0000_0021, 16'h0002}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h002, 32'h0000_0032, 16'h0003}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_WRITE, 10'h003, 32'h0000_0043, 16'h0004}, 1'b0, '0},
        // full table, no match
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0005, 16'h0000}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0043, 16'h0000}, 1'b1, '{1'b1, 16'h4}},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0032, 16'h0000}, 1'b0, '0},
        // size above the table depth is clipped
        '{1'b1, CFG_TABLE_SIZE_LOG2, 16'd15, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0043, 16'h0000}, 1'b0, '0},
        '{1'b1, CFG_TABLE_SIZE_LOG2, 16'd0, '0, 1'b0, '0},
        '{1'b1, CFG_ITEM_COUNT, 16'd0, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0010, 16'h0000}, 1'b1, '{1'b0, 16'h0}},
        '{1'b1, CFG_ITEM_COUNT, 16'd2, '0, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0010, 16'h0000}, 1'b0, '0},
        '{1'b0, '0, '0, '{MODE_LOOKUP, 10'h000, 32'h0000_0021, 16'h0000}, 1'b0, '0}
    };

    linear_probe_hash_lookup u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned active_mask();
        int unsigned sz;
        sz = 1 << cur_log2;
        while (sz > DEPTH && sz > 1)
            sz = sz >> 1;
        return sz - 1;
    endfunction

    function automatic t_out_beat probe_table(input logic [KEY_W-1:0] key);
        t_out_beat   r;
        int unsigned mask;
        int unsigned slot;
        r = '0;
        if (!cur_enabled)
            return r;
        mask = active_mask();
        slot = key & mask;
        for (int unsigned p = 0; p <= mask; p++) begin
            if (tbl_key[slot] == '0)
                break;
            if (tbl_key[slot] == key && tbl_item[slot] < cur_count) begin
                r.found      = 1'b1;
                r.item_index = tbl_item[slot];
                break;
            end
            slot = (slot + 1) & mask;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_TABLE_SIZE_LOG2: cur_log2    = val[LOG2_W-1:0];
            CFG_TABLE_ENABLED:   cur_enabled = val[0];
            CFG_ITEM_COUNT:      cur_count   = val[ITEM_W-1:0];
            default: ;
        endcase
        n_regs++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for all lookup answers, then let a trailing write settle
    task automatic drain();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat ans);
        while (!steady && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (b.mode == MODE_WRITE) begin
            tbl_key[b.slot_index]  = b.key_hash;
            tbl_item[b.slot_index] = b.entry_item;
            n_writes++;
        end else begin
            answer_q.push_back(typed ? ans : probe_table(b.key_hash));
            n_lookups++;
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) out_stall <= !steady && ($urandom_range(0, 99) < 8);

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (answer_q.size() == 0) begin
                $error("result beat with no lookup outstanding");
                err_count++;
            end else begin
                want = answer_q.pop_front();
                if (o_out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_data.found);
                    err_count++;
                end
                if (o_out_data.item_index !== want.item_index) begin
                    $error("item_index: expected %0h, got %0h",
                           want.item_index, o_out_data.item_index);
                    err_count++;
                end
                if (want.found)
                    n_hits++;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_in_beat          b;
        logic [KEY_W-1:0]  pool [8];
        int unsigned       mask;
        int                done_items;
        int                phase;
        int                pick;
        logic [LOG2_W-1:0] lg;
        logic              en;
        logic [ITEM_W-1:0] cnt;

        foreach (tbl_key[i]) begin
            tbl_key[i]  = '0;
            tbl_item[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].answer);
            end
        end

        done_items = 0;
        phase      = 0;
        while (done_items < N_RANDOM) begin
            drain();
            if (phase == 0) begin
                lg  = 4'd10;
                en  = 1'b1;
                cnt = '1;
            end else if (phase == 1) begin
                lg  = '0;
                en  = 1'b0;
                cnt = '0;
            end else begin
                pick = $urandom_range(0, 99);
                lg = (pick < 70) ? LOG2_W'($urandom_range(0, 6)) :
                     (pick < 92) ? LOG2_W'($urandom_range(7, 10)) :
                                   LOG2_W'($urandom_range(11, 15));
                en = ($urandom_range(0, 7) != 0);
                case ($urandom_range(0, 3))
                    0: cnt = '0;
                    1: cnt = '1;
                    2: cnt = ITEM_W'($urandom_range(1, 16));
                    default: cnt = ITEM_W'($urandom);
                endcase
            end
            write_reg(CFG_TABLE_SIZE_LOG2, CFG_DATA_W'(lg));
            write_reg(CFG_TABLE_ENABLED, CFG_DATA_W'(en));
            write_reg(CFG_ITEM_COUNT, cnt);
            mask = active_mask();
            foreach (pool[k])
                pool[k] = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;

            repeat ($urandom_range(20, 50)) begin
                steady = (done_items >= 150 && done_items < 260);
                b.mode = $urandom_range(0, 1) ? MODE_LOOKUP : MODE_WRITE;
                pick = $urandom_range(0, 99);
                b.key_hash = (pick < 80) ? pool[$urandom_range(0, 7)] :
                             (pick < 95) ? $urandom : '0;
                if (cur_count != 0 && $urandom_range(0, 3) != 0)
                    b.entry_item = ITEM_W'($urandom_range(0, cur_count - 1));
                else
                    b.entry_item = ITEM_W'($urandom);
                // writes mostly land near the key's home slot to build probe runs
                if (b.mode == MODE_WRITE && $urandom_range(0, 4) != 0)
                    b.slot_index = SLOT_W'((b.key_hash + $urandom_range(0, 3)) & mask);
                else
                    b.slot_index = SLOT_W'($urandom);
                send_beat(b, 1'b0, '0);
                done_items++;
            end
            phase++;
        end

        steady = 1'b0;
        drain();
        repeat (4 * SETTLE) @(negedge i_clk);

        $display("Covered %0d slot writes and %0d lookups (%0d hits)", n_writes, n_lookups,
                 n_hits);
        $display("over %0d random phases with %0d register writes", phase, n_regs);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
